// File: rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Shared types, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int MaxSteps = 20;
  localparam int XyWidth  = 20;
  localparam int ZWidth   = 21;

  localparam logic signed [ZWidth-1:0] PiQ16 = 21'sd205887;
  localparam logic signed [ZWidth-1:0] PiQ12 = 21'sd12868;

  typedef enum logic [3:0] {
    REG_GOAL_X            = 4'd0,
    REG_GOAL_Y            = 4'd1,
    REG_CRUISE_SPEED      = 4'd2,
    REG_TURN_GAIN         = 4'd3,
    REG_HEADING_TOLERANCE = 4'd4,
    REG_ARRIVE_RADIUS     = 4'd5,
    REG_SLOW_RADIUS       = 4'd6,
    REG_SLOW_SPEED        = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [XyWidth-1:0] x;
    logic signed [XyWidth-1:0] y;
    logic signed [ZWidth-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic               zero;
    logic signed [14:0] hd;
    logic [32:0]        sqx;
    logic [32:0]        sqy;
  } side_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] a;
    case (idx)
      5'd0:    a = 17'd51472;
      5'd1:    a = 17'd30385;
      5'd2:    a = 17'd16055;
      5'd3:    a = 17'd8150;
      5'd4:    a = 17'd4091;
      5'd5:    a = 17'd2047;
      5'd6:    a = 17'd1024;
      5'd7:    a = 17'd512;
      5'd8:    a = 17'd256;
      5'd9:    a = 17'd128;
      5'd10:   a = 17'd64;
      5'd11:   a = 17'd32;
      5'd12:   a = 17'd16;
      5'd13:   a = 17'd8;
      5'd14:   a = 17'd4;
      5'd15:   a = 17'd2;
      5'd16:   a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/gtg_cordic_stage.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation of the arctangent pipeline.
// ----------------------------------------------------------------------------
module gtg_cordic_stage
  import gtg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  cordic_t in_data,
  output logic    out_valid,
  output cordic_t out_data
);

  localparam logic [4:0] StepIdx = 5'(STEP);

  logic signed [XyWidth-1:0] x_sh;
  logic signed [XyWidth-1:0] y_sh;
  logic signed [ZWidth-1:0]  ang;
  cordic_t                   data_next;

  always_comb begin
    x_sh = in_data.x >>> STEP;
    y_sh = in_data.y >>> STEP;
    ang  = $signed({4'b0000, atan_q16(StepIdx)});
    if (in_data.y > 0) begin
      data_next.x = in_data.x + y_sh;
      data_next.y = in_data.y - x_sh;
      data_next.z = in_data.z + ang;
    end else begin
      data_next.x = in_data.x - y_sh;
      data_next.y = in_data.y + x_sh;
      data_next.z = in_data.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// File: rtl/go_to_goal_velocity_command.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command
// Proportional steering towards a configured goal, bearing by pipelined CORDIC.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// pose      start / busy           pose_x, pose_y, pose_heading
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
// result    result_valid strobe    linear_speed, turn_rate, arrived
//
// One pose beat is taken every cycle; busy is high only during reset.
// The input register loads at the accepting edge; pre-rotation, one stage per
// CORDIC iteration and three finishing stages (bearing, multiply, rounding and
// saturation) follow, and the last of them raises the result strobe.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_command
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [14:0] pose_heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  output logic [14:0]        linear_speed,
  output logic signed [19:0] turn_rate,
  output logic               arrived
);

  localparam int Steps   = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int Latency = Steps + 5;

  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic [14:0]        cruise_speed;
  logic [11:0]        turn_gain;
  logic [13:0]        heading_tolerance;
  logic [14:0]        arrive_radius;
  logic [14:0]        slow_radius;
  logic [14:0]        slow_speed;
  logic [29:0]        arrive_sq;
  logic [29:0]        slow_sq;

  logic               accept;
  logic               in_valid;
  logic signed [16:0] in_dx;
  logic signed [16:0] in_dy;
  logic signed [14:0] in_hd;

  cordic_t            pre_next;
  side_t              side_next;
  logic signed [32:0] sqx_full;
  logic signed [32:0] sqy_full;

  logic               cvalid [Steps+1];
  cordic_t            cdata  [Steps+1];
  side_t              side   [Steps+1];

  logic signed [ZWidth-1:0] rnd;
  logic signed [16:0]       bearing;
  logic signed [16:0]       err_next;
  logic                     f1_valid;
  logic signed [16:0]       f1_err;
  logic [33:0]              f1_d2;

  logic [16:0]        aerr;
  logic signed [12:0] gain_s;
  logic signed [29:0] product_next;
  logic [14:0]        speed_next;
  logic               arrived_next;
  logic               f2_valid;
  logic               f2_turning;
  logic signed [29:0] f2_product;
  logic [14:0]        f2_speed;
  logic               f2_arrived;

  logic signed [30:0] rsum;
  logic signed [30:0] rshift;
  logic signed [19:0] turn_sat;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x            <= 16'sd0;
      goal_y            <= 16'sd0;
      cruise_speed      <= 15'd256;
      turn_gain         <= 12'd512;
      heading_tolerance <= 14'd41;
      arrive_radius     <= 15'd26;
      slow_radius       <= 15'd128;
      slow_speed        <= 15'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GOAL_X:            goal_x            <= $signed(cfg_data);
        REG_GOAL_Y:            goal_y            <= $signed(cfg_data);
        REG_CRUISE_SPEED:      cruise_speed      <= cfg_data[14:0];
        REG_TURN_GAIN:         turn_gain         <= cfg_data[11:0];
        REG_HEADING_TOLERANCE: heading_tolerance <= cfg_data[13:0];
        REG_ARRIVE_RADIUS:     arrive_radius     <= cfg_data[14:0];
        REG_SLOW_RADIUS:       slow_radius       <= cfg_data[14:0];
        REG_SLOW_SPEED:        slow_speed        <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    arrive_sq <= 30'(arrive_radius) * 30'(arrive_radius);
    slow_sq   <= 30'(slow_radius) * 30'(slow_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_dx <= 17'(goal_x) - 17'(pose_x);
    in_dy <= 17'(goal_y) - 17'(pose_y);
    in_hd <= pose_heading;
  end

  always_comb begin
    sqx_full = 33'(in_dx) * 33'(in_dx);
    sqy_full = 33'(in_dy) * 33'(in_dy);
    side_next.zero = (in_dx == 17'sd0) && (in_dy == 17'sd0);
    side_next.hd   = in_hd;
    side_next.sqx  = sqx_full;
    side_next.sqy  = sqy_full;
    if (in_dx < 0) begin
      pre_next.x = -XyWidth'(in_dx);
      pre_next.y = -XyWidth'(in_dy);
      pre_next.z = (in_dy >= 0) ? PiQ16 : -PiQ16;
    end else begin
      pre_next.x = XyWidth'(in_dx);
      pre_next.y = XyWidth'(in_dy);
      pre_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid[0] <= 1'b0;
    end else begin
      cvalid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cdata[0] <= pre_next;
    side[0]  <= side_next;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    gtg_cordic_stage #(
      .STEP(k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cvalid[k]),
      .in_data  (cdata[k]),
      .out_valid(cvalid[k+1]),
      .out_data (cdata[k+1])
    );

    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
    end
  end

  always_comb begin
    rnd = (cdata[Steps].z + 21'sd8) >>> 4;
    if (side[Steps].zero) begin
      bearing = 17'sd0;
    end else if (rnd > PiQ12) begin
      bearing = 17'(PiQ12);
    end else if (rnd < -PiQ12) begin
      bearing = 17'(-PiQ12);
    end else begin
      bearing = rnd[16:0];
    end
    err_next = bearing - 17'(side[Steps].hd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= cvalid[Steps];
    end
  end

  always_ff @(posedge clk) begin
    f1_err <= err_next;
    f1_d2  <= 34'(side[Steps].sqx) + 34'(side[Steps].sqy);
  end

  always_comb begin
    aerr         = (f1_err < 0) ? 17'(-f1_err) : 17'(f1_err);
    gain_s       = $signed({1'b0, turn_gain});
    product_next = 30'(gain_s) * 30'(f1_err);
    arrived_next = 1'b0;
    speed_next   = 15'd0;
    if (f1_d2 < 34'(arrive_sq)) begin
      arrived_next = 1'b1;
    end else if (f1_d2 >= 34'(slow_sq)) begin
      speed_next = cruise_speed;
    end else begin
      speed_next = slow_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f2_turning <= aerr > 17'(heading_tolerance);
    f2_product <= product_next;
    f2_speed   <= speed_next;
    f2_arrived <= arrived_next;
  end

  always_comb begin
    rsum   = 31'(f2_product) + 31'sd128;
    rshift = rsum >>> 8;
    if (rshift > 31'sd524287) begin
      turn_sat = 20'sd524287;
    end else if (rshift < -31'sd524288) begin
      turn_sat = -20'sd524288;
    end else begin
      turn_sat = rshift[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    linear_speed <= f2_turning ? 15'd0 : f2_speed;
    turn_rate    <= f2_turning ? turn_sat : 20'sd0;
    arrived      <= f2_turning ? 1'b0 : f2_arrived;
  end

  a_result_follows_accept : assert property (
    @(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, Latency)
  ) else $error("result beat without a pose beat at the pipeline latency");

  a_arrived_stopped : assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && arrived) |-> (linear_speed == 15'd0 && turn_rate == 20'sd0)
  ) else $error("arrived beat with non-zero motion");

  a_turn_only : assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && turn_rate != 20'sd0) |-> (linear_speed == 15'd0 && !arrived)
  ) else $error("turning beat also drives forward");

endmodule

// File: tb/sv/tb_go_to_goal_velocity_command.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command testbench
// Drives pose beats with random gaps and checks every velocity command
// against a CORDIC bearing and steering predictor kept inside the bench.
// The goal, speed, gain, tolerance and radius registers are changed between
// batches, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_go_to_goal_velocity_command;
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  localparam int     CORDIC_STEPS  = 14;
  localparam int     PIPE_LATENCY  = CORDIC_STEPS + 5;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint HALF_TURN_Q12 = 12868;
  localparam longint TURN_CEIL     = 524287;
  localparam longint TURN_FLOOR    = -524288;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [14:0] heading;
  } pose_t;

  typedef struct packed {
    logic [14:0]        speed;
    logic signed [19:0] turn;
    logic               arrived;
  } velocity_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] pose_x = '0;
  logic signed [15:0] pose_y = '0;
  logic signed [14:0] pose_heading = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               result_valid;
  logic [14:0]        linear_speed;
  logic signed [19:0] turn_rate;
  logic               arrived;

  // Register shadow, reset values.
  longint tgt_x    = 0;
  longint tgt_y    = 0;
  longint v_cruise = 256;
  longint k_turn   = 512;
  longint tol_hd   = 41;
  longint r_arrive = 26;
  longint r_slow   = 128;
  longint v_slow   = 128;

  pose_t         pose_queue [$];
  velocity_cmd_t expected_cmds [$];
  logic [15:0]   cfg_plan [8];
  pose_t         next_pose;
  velocity_cmd_t want;
  int            pushed = 0;
  int            accepted = 0;
  int            failures = 0;
  int            cycles = 0;
  int            gap_left = 0;
  bit            beat_done = 1'b0;
  bit            steady_tail = 1'b0;

  go_to_goal_velocity_command #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pose_x      (pose_x),
    .pose_y      (pose_y),
    .pose_heading(pose_heading),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .linear_speed(linear_speed),
    .turn_rate   (turn_rate),
    .arrived     (arrived)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint arctan_q16(int i);
    case (i)
      0:       return 51472;
      1:       return 30385;
      2:       return 16055;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      15:      return 2;
      16:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint bearing_q12(longint vx, longint vy);
    longint ang;
    longint tmp;
    int     steps;
    ang = 0;
    steps = (CORDIC_STEPS > 20) ? 20 : CORDIC_STEPS;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < steps; i++) begin
      tmp = vx;
      if (vy > 0) begin
        vx = vx + (vy >>> i);
        vy = vy - (tmp >>> i);
        ang = ang + arctan_q16(i);
      end else begin
        vx = vx - (vy >>> i);
        vy = vy + (tmp >>> i);
        ang = ang - arctan_q16(i);
      end
    end
    return clamp((ang + 8) >>> 4, -HALF_TURN_Q12, HALF_TURN_Q12);
  endfunction

  function automatic velocity_cmd_t command_for(pose_t p);
    velocity_cmd_t c;
    longint        dx;
    longint        dy;
    longint        hd;
    longint        err;
    longint        d2;
    dx = tgt_x - longint'($signed(p.x));
    dy = tgt_y - longint'($signed(p.y));
    hd = longint'($signed(p.heading));
    err = bearing_q12(dx, dy) - hd;
    c = '0;
    if (((err < 0) ? -err : err) > tol_hd) begin
      c.turn = 20'(clamp((k_turn * err + 128) >>> 8, TURN_FLOOR, TURN_CEIL));
    end else begin
      d2 = dx * dx + dy * dy;
      if (d2 < r_arrive * r_arrive) c.arrived = 1'b1;
      else if (d2 >= r_slow * r_slow) c.speed = 15'(v_cruise);
      else c.speed = 15'(v_slow);
    end
    return c;
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [15:0] data);
    case (reg_index_t'(idx))
      REG_GOAL_X:            tgt_x = longint'($signed(data));
      REG_GOAL_Y:            tgt_y = longint'($signed(data));
      REG_CRUISE_SPEED:      v_cruise = longint'(data[14:0]);
      REG_TURN_GAIN:         k_turn = longint'(data[11:0]);
      REG_HEADING_TOLERANCE: tol_hd = longint'(data[13:0]);
      REG_ARRIVE_RADIUS:     r_arrive = longint'(data[14:0]);
      REG_SLOW_RADIUS:       r_slow = longint'(data[14:0]);
      REG_SLOW_SPEED:        v_slow = longint'(data[14:0]);
      default: ;
    endcase
  endfunction

  function automatic pose_t pose_of(longint x, longint y, longint h);
    pose_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.heading = 15'(h);
    return p;
  endfunction

  // Mostly poses whose heading lies near the bearing, some close to the goal,
  // so that the driving branch and both radii are reached often.
  function automatic pose_t shaped_pose();
    longint px;
    longint py;
    longint reach;
    longint spread;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return pose_of($urandom, $urandom, $urandom);
    if (pick < 65) begin
      px = longint'($signed(16'($urandom)));
      py = longint'($signed(16'($urandom)));
    end else begin
      reach = 2 * r_slow + 64;
      px = clamp(tgt_x + longint'($urandom_range(0, 2 * reach)) - reach, -32768, 32767);
      py = clamp(tgt_y + longint'($urandom_range(0, 2 * reach)) - reach, -32768, 32767);
      if ($urandom_range(0, 15) == 0) begin
        px = tgt_x;
        py = tgt_y;
      end
    end
    spread = ((tol_hd > 16384) ? 16384 : tol_hd) + 3;
    return pose_of(px, py, clamp(bearing_q12(tgt_x - px, tgt_y - py)
                                 + longint'($urandom_range(0, 2 * spread)) - spread,
                                 -16384, 16383));
  endfunction

  function automatic logic [15:0] with_noise(longint v, int w);
    logic [15:0] m;
    m = 16'((longint'(1) << w) - 1);
    return (16'($urandom) & ~m) | (16'(v) & m);
  endfunction

  function automatic void check_field(string what, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, got_v);
      failures++;
    end
  endfunction

  task automatic push_pose(pose_t p);
    pose_queue.push_back(p);
    pushed++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic commit_settings();
    reg_index_t r;
    r = r.first();
    do begin
      write_reg(r, cfg_plan[r]);
      r = r.next();
    end while (r != r.first());
    write_reg(4'(REG_SLOW_SPEED) + 4'($urandom_range(1, 8)), 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_random_settings();
    if ($urandom_range(0, 1) == 1) begin
      cfg_plan[REG_GOAL_X] = 16'($urandom);
      cfg_plan[REG_GOAL_Y] = 16'($urandom);
    end else begin
      cfg_plan[REG_GOAL_X] = 16'(int'($urandom_range(0, 4000)) - 2000);
      cfg_plan[REG_GOAL_Y] = 16'(int'($urandom_range(0, 4000)) - 2000);
    end
    cfg_plan[REG_CRUISE_SPEED] = 16'($urandom);
    cfg_plan[REG_TURN_GAIN] = 16'($urandom);
    cfg_plan[REG_HEADING_TOLERANCE] = ($urandom_range(0, 3) == 0) ?
        16'($urandom) : with_noise($urandom_range(0, 400), 14);
    cfg_plan[REG_ARRIVE_RADIUS] = ($urandom_range(0, 3) == 0) ?
        16'($urandom) : with_noise($urandom_range(0, 800), 15);
    cfg_plan[REG_SLOW_RADIUS] = ($urandom_range(0, 3) == 0) ?
        16'($urandom) : with_noise($urandom_range(0, 4000), 15);
    cfg_plan[REG_SLOW_SPEED] = 16'($urandom);
  endtask

  task automatic wait_drained();
    while (accepted != pushed || expected_cmds.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic run_batch(int n);
    @(posedge clk);
    repeat (n) push_pose(shaped_pose());
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !beat_done)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pose_queue.size() != 0) begin
        next_pose = pose_queue.pop_front();
        pose_x <= next_pose.x;
        pose_y <= next_pose.y;
        pose_heading <= next_pose.heading;
        start <= 1'b1;
        if (!steady_tail && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 15);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      beat_done = start && !busy;
      if (beat_done) begin
        expected_cmds.push_back(command_for(pose_of(pose_x, pose_y, pose_heading)));
        accepted++;
      end
      if (result_valid) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result beat, speed %0d turn %0d arrived %0d",
                   $time, linear_speed, turn_rate, arrived);
          failures++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("linear_speed", longint'(want.speed), longint'(linear_speed));
          check_field("turn_rate", longint'($signed(want.turn)), longint'(turn_rate));
          check_field("arrived", longint'(want.arrived), longint'(arrived));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_to_goal_velocity_command regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: goal at the origin, default gains and radii.
    @(posedge clk);
    push_pose(pose_of(0, 0, 0));
    push_pose(pose_of(0, 0, 16383));
    push_pose(pose_of(0, 0, -16384));
    push_pose(pose_of(-32768, -32768, 0));
    push_pose(pose_of(-32768, -32768, 3217));
    push_pose(pose_of(32767, 0, 12868));
    push_pose(pose_of(32767, 0, -12868));
    push_pose(pose_of(32767, 1, -12868));
    push_pose(pose_of(32767, -32768, 6434));
    push_pose(pose_of(-50, 0, 0));
    push_pose(pose_of(-10, 0, 0));
    push_pose(pose_of(-26, 0, 0));
    push_pose(pose_of(-25, 0, 0));
    push_pose(pose_of(-128, 0, 0));
    push_pose(pose_of(-127, 0, 0));
    push_pose(pose_of(0, -1000, 6434));
    push_pose(pose_of(0, 1000, -6434));
    push_pose(pose_of(500, 500, -9651));
    push_pose(pose_of(-1, -1, 3217));
    push_pose(pose_of(32767, 32767, -9651));
    push_pose(pose_of(-1000, 0, 41));
    push_pose(pose_of(-1000, 0, 42));
    wait_drained();

    cfg_plan = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    commit_settings();
    run_batch(60);

    cfg_plan = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    commit_settings();
    run_batch(60);

    for (int ph = 0; ph < 8; ph++) begin
      plan_random_settings();
      commit_settings();
      steady_tail = (ph == 7);
      run_batch(128);
    end

    if (failures == 0) begin
      $display("go_to_goal_velocity_command regression: pass");
    end else begin
      $display("go_to_goal_velocity_command regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gtg_pkg.sv
rtl/gtg_cordic_stage.sv
rtl/go_to_goal_velocity_command.sv
tb/sv/tb_go_to_goal_velocity_command.sv
